[hdl/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Default operand width for base, exponent, modulus and result.
  localparam int unsigned OperandWidthDef = 32;

  // Register indexes on the configuration port.
  localparam logic RegKeyExponent = 1'b0;
  localparam logic RegKeyModulus  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MUL_RES,
    ST_MUL_SQ,
    ST_DONE
  } modexp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // take a new base and a copy of the exponent
    logic div_step;    // one restoring remainder step on the base
    logic div_last;    // last remainder step: the remainder becomes the square
    logic mul_start;   // clear the accumulator and pick the multiplicands
    logic mul_a_res;   // multiplicand is the running result, else the square
    logic mul_step;    // one shift-and-add step of the modular multiply
    logic res_take;    // product goes to the running result
    logic sq_take;     // product goes to the square
    logic exp_shift;   // move on to the next exponent bit
    logic out_load;    // write the running result to the output register
  } modexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_small;   // modulus is zero or one
    logic exp_zero;    // no set exponent bits remain
    logic exp_lsb;     // current exponent bit
    logic out_free;    // output register can take a result this cycle
  } modexp_sts_t;

endpackage

[hdl/modexp_ctrl.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences the base reduction and the square-and-multiply loop, and counts
// the bit steps of the shared shift-and-add multiplier.
// ----------------------------------------------------------------------------
module modexp_ctrl import modexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  modexp_sts_t sts_i,
  output modexp_cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(OPERAND_WIDTH - 1);

  modexp_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic cnt_zero;

  assign cnt_zero = (cnt_q == '0);

  // State and bit counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntLast;
          // A modulus of zero or one leaves the result at zero.
          state_d    = sts_i.mod_small ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CntW'(1);
        if (cnt_zero) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_BIT;
        end
      end
      ST_BIT: begin
        if (sts_i.exp_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_a_res = sts_i.exp_lsb;
          cnt_d           = CntLast;
          state_d         = sts_i.exp_lsb ? ST_MUL_RES : ST_MUL_SQ;
        end
      end
      ST_MUL_RES: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - CntW'(1);
        if (cnt_zero) begin
          // Take the product and start squaring right away.
          cmd_o.res_take  = 1'b1;
          cmd_o.mul_start = 1'b1;
          cnt_d           = CntLast;
          state_d         = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - CntW'(1);
        if (cnt_zero) begin
          cmd_o.sq_take   = 1'b1;
          cmd_o.exp_shift = 1'b1;
          state_d         = ST_BIT;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/modexp_dp.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the base remainder, the running result, the square, the exponent
// shift register, a bit-serial modular multiplier and the output register.
// ----------------------------------------------------------------------------
module modexp_dp import modexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  modexp_cmd_t              cmd_i,
  output modexp_sts_t              sts_o,
  input  logic [OPERAND_WIDTH-1:0] base_i,
  input  logic [OPERAND_WIDTH-1:0] key_exponent_i,
  input  logic [OPERAND_WIDTH-1:0] key_modulus_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [OPERAND_WIDTH-1:0] result_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic [W-1:0] dvd_q, rem_q, rem_d;
  logic [W-1:0] res_q, sq_q, exp_q;
  logic [W-1:0] acc_q, acc_d, mul_a_q, mul_b_q;
  logic [W-1:0] dbl;
  logic [W:0]   div_t;
  logic         out_valid_q;
  logic [W-1:0] out_q;
  logic         mod_small;

  // (a + b) mod m for a and b below m.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  assign mod_small = (key_modulus_i <= W'(1));

  // One restoring remainder step: bring in the next base bit.
  always_comb begin
    div_t = {rem_q, dvd_q[W-1]};
    if (div_t >= {1'b0, key_modulus_i}) begin
      div_t = div_t - {1'b0, key_modulus_i};
    end
    rem_d = div_t[W-1:0];
  end

  // One shift-and-add step: double, then add the multiplicand on a set bit.
  always_comb begin
    dbl   = add_mod(acc_q, acc_q, key_modulus_i);
    acc_d = mul_b_q[W-1] ? add_mod(dbl, mul_a_q, key_modulus_i) : dbl;
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q <= base_i;
      rem_q <= '0;
      exp_q <= key_exponent_i;
      res_q <= mod_small ? '0 : W'(1);
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.div_last) begin
      sq_q <= rem_d;
    end
    if (cmd_i.mul_step) begin
      acc_q   <= acc_d;
      mul_b_q <= {mul_b_q[W-2:0], 1'b0};
    end
    if (cmd_i.res_take) begin
      res_q <= acc_d;
    end
    if (cmd_i.sq_take) begin
      sq_q <= acc_d;
    end
    if (cmd_i.mul_start) begin
      acc_q   <= '0;
      mul_a_q <= cmd_i.mul_a_res ? res_q : sq_q;
      mul_b_q <= sq_q;
    end
    if (cmd_i.exp_shift) begin
      exp_q <= {1'b0, exp_q[W-1:1]};
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.mod_small = mod_small;
  assign sts_o.exp_zero  = (exp_q == '0);
  assign sts_o.exp_lsb   = exp_q[0];
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

[hdl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base_value ^ key_exponent mod key_modulus for each request.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written over the APB port: key_exponent at offset 0 and
//   key_modulus at offset 4 (offsets 0 and 8 for operands wider than 32 bits).
//   Write the key only while no request is in flight.
//   Each request on the input channel (in_valid_i, in_stall_o) carries one
//   base; one result leaves on the output channel (out_valid_o, out_stall_i).
//   One request is worked on at a time; in_stall_o is high while it runs.
//   The base is first reduced modulo key_modulus, one remainder bit a cycle.
//   Each exponent bit up to the highest set one then gets a multiply into the
//   result if the bit is set and then a squaring, all on a single bit-serial
//   modular multiplier; the result then goes to the output register. A
//   modulus of zero or one skips the reduction and the loop and gives 0.
//   The next request is taken in the cycle after the result is loaded.
//   The result sits in an output register, so the next request is taken while
//   it waits; a stalled result holds until it is taken.
//   Reset sets the exponent and modulus to 1 and empties the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation import modexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef,
  localparam int unsigned DataW = (OPERAND_WIDTH > 32) ? 64 : 32,
  localparam int unsigned AddrW = (OPERAND_WIDTH > 32) ? 4 : 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  // Input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OPERAND_WIDTH-1:0] base_value_i,
  // Output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [OPERAND_WIDTH-1:0] power_result_o
);

  logic [OPERAND_WIDTH-1:0] key_exponent_q, key_modulus_q;
  logic        reg_sel;
  logic        cfg_wr;
  modexp_cmd_t cmd;
  modexp_sts_t sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_exponent_q <= OPERAND_WIDTH'(1);
      key_modulus_q  <= OPERAND_WIDTH'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegKeyExponent: key_exponent_q <= pwdata[OPERAND_WIDTH-1:0];
        RegKeyModulus:  key_modulus_q  <= pwdata[OPERAND_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_sel)
      RegKeyExponent: prdata = DataW'(key_exponent_q);
      RegKeyModulus:  prdata = DataW'(key_modulus_q);
      default:        prdata = '0;
    endcase
  end

  modexp_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  modexp_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .base_i        (base_value_i),
    .key_exponent_i(key_exponent_q),
    .key_modulus_i (key_modulus_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_o      (power_result_o)
  );

endmodule

[hdl/modexp_checker.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level checks on the request channels, bound to the top level.
// ----------------------------------------------------------------------------
module modexp_checker import modexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [OPERAND_WIDTH-1:0] power_result_o
);

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(power_result_o))
    else $error("result changed while stalled");

  // Once a request is taken, the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // No result is produced at the same edge as a new request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result issued at request acceptance");

endmodule

bind modular_exponentiation modexp_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_modexp_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives bases into the block under a series of keys written over the APB
// port, computes base ^ exponent mod modulus for every accepted request and
// compares each result in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import modexp_pkg::*;

  localparam int unsigned OpW       = OperandWidthDef;
  localparam int unsigned ClkPeriod = 4;
  localparam int unsigned DrainCyc  = 2200;

  // Clock, reset and block inputs, all known from time zero.
  logic           clk_i        = 1'b0;
  logic           rst_ni       = 1'b0;
  logic           psel         = 1'b0;
  logic           penable      = 1'b0;
  logic           pwrite       = 1'b0;
  logic [2:0]     paddr        = '0;
  logic [31:0]    pwdata       = '0;
  logic [31:0]    prdata;
  logic           pready;
  logic           in_valid_i   = 1'b0;
  logic           in_stall_o;
  logic [OpW-1:0] base_value_i = '0;
  logic           out_valid_o;
  logic           out_stall_i  = 1'b0;
  logic [OpW-1:0] power_result_o;

  // Key as the block should hold it.
  logic [OpW-1:0] key_exp = 1;
  logic [OpW-1:0] key_mod = 1;

  logic [OpW-1:0] base_pending_q[$];
  logic [OpW-1:0] power_expected_q[$];
  int unsigned    in_gap_max    = 0;
  int unsigned    out_stall_max = 0;
  int unsigned    in_gap        = 0;
  int unsigned    out_wait      = 0;
  int unsigned    err_cnt       = 0;

  modular_exponentiation i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .base_value_i  (base_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .power_result_o(power_result_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Right-to-left square and multiply, reducing after every product.
  function automatic logic [OpW-1:0] power_mod(input logic [OpW-1:0] base,
                                               input logic [OpW-1:0] expo,
                                               input logic [OpW-1:0] modulus);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m;
    int          i;
    m = {32'b0, modulus};
    if (m <= 1) return '0;
    acc = 64'd1;
    sq  = {32'b0, base} % m;
    for (i = 0; i < OpW; i++) begin
      if (expo[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[OpW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    err_cnt++;
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic key_write(input logic reg_idx, input logic [OpW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == RegKeyExponent) key_exp = value;
    else key_mod = value;
  endtask

  task automatic set_key(input logic [OpW-1:0] expo, input logic [OpW-1:0] modulus);
    key_write(RegKeyExponent, expo);
    key_write(RegKeyModulus, modulus);
  endtask

  // Wait until every queued request has been taken and answered.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (base_pending_q.size() != 0 || in_valid_i || power_expected_q.size() != 0);
  endtask

  // Bases lean toward the edges of the current modulus.
  function automatic logic [OpW-1:0] pick_base(input logic [OpW-1:0] modulus);
    case ($urandom_range(0, 9)) inside
      0: return '0;
      1: return '1;
      2: return modulus - 1;
      3: return modulus;
      [4:5]: return (modulus != 0) ? $urandom % modulus : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Request driver: presents queued bases and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      base_value_i <= '0;
      in_gap       <= 0;
    end else begin : drv_body
      int unsigned gap;
      gap = in_gap;
      if (in_valid_i && !in_stall_o) begin
        power_expected_q.push_back(power_mod(base_value_i, key_exp, key_mod));
        gap = $urandom_range(0, in_gap_max);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap != 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (base_pending_q.size() != 0) begin
          in_valid_i   <= 1'b1;
          base_value_i <= base_pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      in_gap <= gap;
    end
  end

  // Result monitor: checks each taken result, then stalls a random while.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait    <= 0;
    end else begin : mon_body
      int unsigned    wait_n;
      logic [OpW-1:0] want;
      wait_n = out_wait;
      if (out_valid_o && !out_stall_i) begin
        if (power_expected_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding",
                                    power_result_o));
        end else begin
          want = power_expected_q.pop_front();
          if (power_result_o !== want)
            report_mismatch($sformatf("power_result %h, expected %h",
                                      power_result_o, want));
        end
        wait_n = $urandom_range(0, out_stall_max);
      end else if (out_valid_o && wait_n != 0) begin
        wait_n--;
      end
      out_wait    <= wait_n;
      out_stall_i <= (wait_n != 0);
    end
  end

  // Stimulus: directed keys and bases first, then random keys.
  initial begin
    int             phase;
    int             n;
    logic [OpW-1:0] e;
    logic [OpW-1:0] m;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key: modulus one, so every result is zero.
    base_pending_q.push_back(32'h0);
    base_pending_q.push_back(32'h1);
    base_pending_q.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Exponent zero gives one, even for a base that reduces to zero.
    set_key(32'h0, 32'hFFFF_FFFF);
    base_pending_q.push_back(32'h0);
    base_pending_q.push_back(32'hFFFF_FFFF);
    base_pending_q.push_back(32'h1234_5678);
    wait_drained();

    // Modulus zero has no reduction and gives zero.
    in_gap_max    = 15;
    out_stall_max = 15;
    set_key(32'd65537, 32'h0);
    base_pending_q.push_back(32'h0);
    base_pending_q.push_back(32'hFFFF_FFFF);
    base_pending_q.push_back(32'hA5A5_5A5A);
    wait_drained();

    // Widest key: every exponent bit set, largest modulus.
    in_gap_max    = 0;
    out_stall_max = 15;
    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    base_pending_q.push_back(32'h0);
    base_pending_q.push_back(32'h1);
    base_pending_q.push_back(32'hFFFF_FFFE);
    base_pending_q.push_back(32'hFFFF_FFFF);
    base_pending_q.push_back(32'h8000_0000);
    wait_drained();

    // Textbook key pair: encrypt, then decrypt, with bases at and above n.
    in_gap_max    = 15;
    out_stall_max = 0;
    set_key(32'd17, 32'd3233);
    base_pending_q.push_back(32'd65);
    base_pending_q.push_back(32'd3232);
    base_pending_q.push_back(32'd3233);
    base_pending_q.push_back(32'd5000);
    wait_drained();
    set_key(32'd2753, 32'd3233);
    base_pending_q.push_back(32'd2790);
    base_pending_q.push_back(32'd0);
    base_pending_q.push_back(32'd1);
    base_pending_q.push_back(32'd65);
    wait_drained();

    // Random keys, each followed by a burst of bases.
    for (phase = 0; phase < 16; phase++) begin
      case ($urandom_range(0, 9))
        0: e = $urandom_range(0, 255);
        1: e = 32'd65537;
        2: e = '1;
        3: e = '0;
        default: e = $urandom;
      endcase
      case ($urandom_range(0, 11))
        0: m = $urandom_range(2, 65535);
        1: m = '1;
        2: m = 32'h8000_0000;
        3: m = $urandom_range(0, 1);
        4: m = $urandom_range(2, 16);
        default: m = $urandom;
      endcase
      in_gap_max    = (phase % 4 == 1 || phase % 4 == 3) ? 15 : 0;
      out_stall_max = (phase % 4 >= 2) ? 15 : 0;
      set_key(e, m);
      for (n = 0; n < 16; n++) base_pending_q.push_back(pick_base(m));
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DrainCyc) @(posedge clk_i);
    if (power_expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", power_expected_q.size()));
    if (err_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(12_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
